/* hdl/ncs_pkg.sv */
// ----------------------------------------------------------------------------
// Nested comment stripper package
// Character codes, lexer mode codes, end status codes and shared types.
// ----------------------------------------------------------------------------
package ncs_pkg;

    // Default nesting depth counter width.
    localparam int DEPTH_BITS_DEF = 8;

    // Result queue depth. It must be a power of two of at least 2.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Lexer modes.
    localparam logic [1:0] MODE_CODE   = 2'd0;
    localparam logic [1:0] MODE_STRING = 2'd1;
    localparam logic [1:0] MODE_BLOCK  = 2'd2;
    localparam logic [1:0] MODE_LINE   = 2'd3;

    // End status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_OPEN_BLOCK = 2'd1;
    localparam logic [1:0] ST_OPEN_LINE  = 2'd2;
    localparam logic [1:0] ST_OPEN_STR   = 2'd3;

    // Characters with a meaning to the lexer.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // One result entry in the output queue.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } t_result;

    // Outcome of handling one byte with no lookahead in front of it.
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic [1:0] mode;
        logic       hold;
        logic       pend;
    } t_single;

    // Single-byte rule of the lexer.
    function automatic t_single single_step(input logic [1:0] mode, input logic pend,
                                            input logic [7:0] c, input logic last);
        t_single s;
        s.emit = 1'b1;
        s.data = c;
        s.mode = mode;
        s.hold = 1'b0;
        s.pend = pend;
        unique case (mode)
            MODE_CODE: begin
                if (c == CH_QUOTE) begin
                    s.mode = MODE_STRING;
                end else if (c == CH_SLASH && !last) begin
                    s.hold = 1'b1;
                    s.emit = 1'b0;
                end
            end
            MODE_STRING: begin
                if (pend) begin
                    s.pend = 1'b0;
                end else if (c == CH_BSLASH && !last) begin
                    s.pend = 1'b1;
                end else if (c == CH_QUOTE) begin
                    s.mode = MODE_CODE;
                end
            end
            MODE_BLOCK: begin
                if ((c == CH_SLASH || c == CH_STAR) && !last) begin
                    s.hold = 1'b1;
                    s.emit = 1'b0;
                end else begin
                    s.data = (c == CH_NL) ? CH_NL : CH_SPACE;
                end
            end
            MODE_LINE: begin
                if (c == CH_NL) begin
                    s.mode = MODE_CODE;
                end else begin
                    s.data = CH_SPACE;
                end
            end
        endcase
        return s;
    endfunction

endpackage

/* hdl/nested_comment_stripper_unit.sv */
// ----------------------------------------------------------------------------
// Nested comment stripper unit
// Replaces comment bytes of a source text stream with spaces.
// ----------------------------------------------------------------------------
// The unit takes source text one byte per transaction on the slave stream and
// returns the same text on the master stream with every comment byte turned
// into a space. Block comments nest up to 2^DEPTH_BITS - 1 levels, line
// comments end at a newline that is passed through, newlines inside block
// comments are kept, and a backslash inside a string escapes the next byte.
// A slash in code, or a slash or star in a block comment, is held for one
// byte to see whether it starts a pair, so an input byte yields zero, one or
// two output bytes. Every text produces at least one output byte for its
// final input byte, and that output carries tlast together with an end
// status in tuser: ok, open block comment, open line comment or open string.
// After the final byte the lexer state returns to its reset values. One input
// byte can be accepted every clock cycle as long as the output queue has room
// for two results; the first result appears in the next cycle. The output
// side moves one byte per cycle with a ready receiver. Only an input that
// releases a held byte yields two results, and the input right after it
// yields at most one, so with a receiver that takes a byte in every cycle the
// four-entry result queue never holds more than two results and the slave
// stream accepts a byte in every cycle. Input stalls only when the receiver
// holds back and three or more results wait in the queue.
module nested_comment_stripper_unit
    import ncs_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Slave stream: source text.
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // in_last
    // Master stream: stripped text.
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,   // out_last
    output logic [1:0] o_m_axis_tuser    // [1:0] end_status
);

    // Lexer state.
    logic [1:0]            r_mode, n_mode;
    logic [DEPTH_BITS-1:0] r_nest, n_nest;
    logic [7:0]            r_held, n_held;
    logic                  r_held_valid, n_held_valid;
    logic                  r_pend, n_pend;

    // Result queue.
    t_result               r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]      r_count, n_count;

    logic                  in_acc;
    logic                  out_acc;
    t_result               res0, res1;
    logic [1:0]            nres;
    t_single               sgl;
    logic [1:0]            end_st;
    logic [PTR_W-1:0]      wr_ptr_p1;

    assign o_s_axis_tready = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_count != '0);
    assign out_acc         = o_m_axis_tvalid && i_m_axis_tready;
    assign wr_ptr_p1       = PTR_W'(r_wr_ptr + 1'b1);

    // The single-byte rule always sees the current mode: a held byte that
    // does not form a pair never changes the mode.
    assign sgl = single_step(r_mode, r_pend, i_s_axis_tdata, i_s_axis_tlast);

    // One pass of the lexer for the byte on the slave stream.
    always_comb begin
        n_mode       = r_mode;
        n_nest       = r_nest;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_pend       = r_pend;
        res0         = '{data: CH_SPACE, last: 1'b0, status: ST_OK};
        res1         = '{data: CH_SPACE, last: 1'b0, status: ST_OK};
        nres         = 2'd0;
        end_st       = ST_OK;

        if (r_held_valid) begin
            n_held_valid = 1'b0;
            n_held       = '0;
            if (r_mode == MODE_CODE && r_held == CH_SLASH
                    && i_s_axis_tdata == CH_STAR) begin
                // Opening of a block comment.
                n_mode = MODE_BLOCK;
                n_nest = DEPTH_BITS'(1);
                nres   = 2'd2;
            end else if (r_mode == MODE_CODE && r_held == CH_SLASH
                    && i_s_axis_tdata == CH_SLASH) begin
                n_mode = MODE_LINE;
                nres   = 2'd2;
            end else if (r_mode == MODE_BLOCK && r_held == CH_SLASH
                    && i_s_axis_tdata == CH_STAR) begin
                // Nested opening; the depth saturates at its maximum.
                if (r_nest != '1) begin
                    n_nest = r_nest + 1'b1;
                end
                nres = 2'd2;
            end else if (r_mode == MODE_BLOCK && r_held == CH_STAR
                    && i_s_axis_tdata == CH_SLASH) begin
                // Closing pair; a closing at zero depth also returns to code.
                if (r_nest != '0) begin
                    n_nest = r_nest - 1'b1;
                end
                if (r_nest <= DEPTH_BITS'(1)) begin
                    n_mode = MODE_CODE;
                end
                nres = 2'd2;
            end else begin
                // No pair: release the held byte, then treat the new byte alone.
                res0.data    = (r_mode == MODE_BLOCK) ? CH_SPACE : r_held;
                res1.data    = sgl.data;
                nres         = sgl.emit ? 2'd2 : 2'd1;
                n_mode       = sgl.mode;
                n_pend       = sgl.pend;
                n_held_valid = sgl.hold;
                n_held       = sgl.hold ? i_s_axis_tdata : 8'h00;
            end
        end else begin
            res0.data    = sgl.data;
            nres         = sgl.emit ? 2'd1 : 2'd0;
            n_mode       = sgl.mode;
            n_pend       = sgl.pend;
            n_held_valid = sgl.hold;
            n_held       = sgl.hold ? i_s_axis_tdata : r_held;
        end

        if (i_s_axis_tlast) begin
            unique case (n_mode)
                MODE_BLOCK:  end_st = ST_OPEN_BLOCK;
                MODE_LINE:   end_st = ST_OPEN_LINE;
                MODE_STRING: end_st = ST_OPEN_STR;
                MODE_CODE:   end_st = ST_OK;
            endcase
            // The final byte is never held, so at least one result exists.
            if (nres == 2'd2) begin
                res1.last   = 1'b1;
                res1.status = end_st;
            end else begin
                res0.last   = 1'b1;
                res0.status = end_st;
            end
            n_mode       = MODE_CODE;
            n_nest       = '0;
            n_held       = '0;
            n_held_valid = 1'b0;
            n_pend       = 1'b0;
        end
    end

    always_comb begin
        n_count = r_count;
        if (in_acc) begin
            n_count = CNT_W'(n_count + CNT_W'(nres));
        end
        if (out_acc) begin
            n_count = CNT_W'(n_count - 1'b1);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_CODE;
            r_nest       <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_pend       <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (in_acc) begin
                r_mode       <= n_mode;
                r_nest       <= n_nest;
                r_held       <= n_held;
                r_held_valid <= n_held_valid;
                r_pend       <= n_pend;
                r_wr_ptr     <= PTR_W'(r_wr_ptr + PTR_W'(nres));
            end
            if (out_acc) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            end
            r_count <= n_count;
        end
    end

    // Queue payload, written at up to two consecutive entries.
    always_ff @(posedge i_clk) begin
        if (in_acc && nres != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (in_acc && nres == 2'd2) begin
            r_fifo[wr_ptr_p1] <= res1;
        end
    end

    assign o_m_axis_tdata = r_fifo[r_rd_ptr].data;
    assign o_m_axis_tlast = r_fifo[r_rd_ptr].last;
    assign o_m_axis_tuser = r_fifo[r_rd_ptr].status;

    // The queue never holds more results than it has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // The final byte of a text leaves the lexer in its reset state.
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_s_axis_tlast |=>
            r_mode == MODE_CODE && r_nest == '0 && !r_held_valid && !r_pend)
        else $error("lexer state not cleared after final byte");

    // A lookahead byte is only held in code or block comment mode.
    a_held_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (r_mode == MODE_CODE || r_mode == MODE_BLOCK))
        else $error("lookahead byte held in wrong mode");

    // An escape is only pending inside a string.
    a_pend_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_mode == MODE_STRING)
        else $error("escape pending outside a string");

endmodule

/* sim/ncs_stream_checker.sv */
// ----------------------------------------------------------------------------
// Nested comment stripper stream checker
// Watches both streams, predicts the stripped text and compares every result.
// ----------------------------------------------------------------------------
module ncs_stream_checker
    import ncs_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,    // [7:0] in_byte
    input  logic       i_in_last,    // in_last
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_data,   // [7:0] out_byte
    input  logic       i_out_last,   // out_last
    input  logic [1:0] i_out_user,   // [1:0] end_status
    output int         o_fail_count,
    output int         o_pending
);

    // Shadow lexer state.
    logic [1:0]            lex_state;
    logic [DEPTH_BITS-1:0] nest_level;
    logic [7:0]            look_byte;
    logic                  look_valid;
    logic                  esc_pending;

    t_result stripped_q[$];
    t_result step_res[2];
    int      step_n;
    int      fails;
    t_result oldest;

    task clear_lexer();
        lex_state   = MODE_CODE;
        nest_level  = '0;
        look_byte   = 8'h00;
        look_valid  = 1'b0;
        esc_pending = 1'b0;
    endtask

    task put_byte(input logic [7:0] b);
        if (step_n < 2) begin
            step_res[step_n] = '{data: b, last: 1'b0, status: ST_OK};
            step_n++;
        end
    endtask

    // A byte with no lookahead in front of it.
    task lex_plain(input logic [7:0] c, input logic is_last);
        case (lex_state)
            MODE_CODE: begin
                if (c == CH_QUOTE) begin
                    lex_state = MODE_STRING;
                    put_byte(c);
                end else if (c == CH_SLASH && !is_last) begin
                    look_byte  = c;
                    look_valid = 1'b1;
                end else begin
                    put_byte(c);
                end
            end
            MODE_STRING: begin
                if (esc_pending) begin
                    esc_pending = 1'b0;
                end else if (c == CH_BSLASH && !is_last) begin
                    esc_pending = 1'b1;
                end else if (c == CH_QUOTE) begin
                    lex_state = MODE_CODE;
                end
                put_byte(c);
            end
            MODE_BLOCK: begin
                if ((c == CH_SLASH || c == CH_STAR) && !is_last) begin
                    look_byte  = c;
                    look_valid = 1'b1;
                end else begin
                    put_byte((c == CH_NL) ? CH_NL : CH_SPACE);
                end
            end
            default: begin
                if (c == CH_NL) begin
                    lex_state = MODE_CODE;
                    put_byte(CH_NL);
                end else begin
                    put_byte(CH_SPACE);
                end
            end
        endcase
    endtask

    // Works out the results of one accepted input byte and queues them.
    task strip_byte(input logic [7:0] c, input logic is_last);
        logic [7:0] h;
        logic [1:0] st;
        step_n = 0;
        if (look_valid) begin
            h          = look_byte;
            look_valid = 1'b0;
            look_byte  = 8'h00;
            if (lex_state == MODE_CODE && h == CH_SLASH && c == CH_STAR) begin
                lex_state  = MODE_BLOCK;
                nest_level = DEPTH_BITS'(1);
                put_byte(CH_SPACE);
                put_byte(CH_SPACE);
            end else if (lex_state == MODE_CODE && h == CH_SLASH && c == CH_SLASH) begin
                lex_state = MODE_LINE;
                put_byte(CH_SPACE);
                put_byte(CH_SPACE);
            end else if (lex_state == MODE_BLOCK && h == CH_SLASH && c == CH_STAR) begin
                if (nest_level != '1) nest_level = nest_level + 1'b1;
                put_byte(CH_SPACE);
                put_byte(CH_SPACE);
            end else if (lex_state == MODE_BLOCK && h == CH_STAR && c == CH_SLASH) begin
                if (nest_level != '0) nest_level = nest_level - 1'b1;
                if (nest_level == '0) lex_state = MODE_CODE;
                put_byte(CH_SPACE);
                put_byte(CH_SPACE);
            end else begin
                put_byte((lex_state == MODE_BLOCK) ? CH_SPACE : h);
                lex_plain(c, is_last);
            end
        end else begin
            lex_plain(c, is_last);
        end

        if (is_last) begin
            case (lex_state)
                MODE_BLOCK:  st = ST_OPEN_BLOCK;
                MODE_LINE:   st = ST_OPEN_LINE;
                MODE_STRING: st = ST_OPEN_STR;
                default:     st = ST_OK;
            endcase
            if (step_n > 0) begin
                step_res[step_n-1].last   = 1'b1;
                step_res[step_n-1].status = st;
            end
            clear_lexer();
        end

        for (int k = 0; k < step_n; k++) stripped_q = {stripped_q, step_res[k]};
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_lexer();
            stripped_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) strip_byte(i_in_data, i_in_last);
            if (i_out_valid && i_out_ready) begin
                if (stripped_q.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected result: data %02h last %0d status %0d",
                                 i_out_data, i_out_last, i_out_user);
                    fails++;
                end else begin
                    oldest = stripped_q.pop_front();
                    if (oldest.data !== i_out_data || oldest.last !== i_out_last ||
                        oldest.status !== i_out_user) begin
                        if (fails < 10)
                            $display("mismatch: expected data %02h last %0d status %0d, %s",
                                     oldest.data, oldest.last, oldest.status,
                                     $sformatf("got data %02h last %0d status %0d",
                                               i_out_data, i_out_last, i_out_user));
                        fails++;
                    end
                end
            end
        end
        o_pending    <= stripped_q.size();
        o_fail_count <= fails;
    end

endmodule

/* sim/nested_comment_stripper_unit_tb.sv */
// ----------------------------------------------------------------------------
// Nested comment stripper unit testbench
// Drives source texts into the unit and lets a checker verify the output.
// ----------------------------------------------------------------------------
// The top makes stimulus only. A short directed set covers the extreme byte
// values, every lexer mode, each end status, held bytes that do not form a
// pair, and the last-byte rules. Random texts built mostly from comment and
// string tokens then follow, with one deeply nested text that drives the
// nesting counter into saturation. The stream checker beside the unit
// predicts every output transaction and counts failures; the top only waits
// until nothing is expected any more and gives the verdict.
module nested_comment_stripper_unit_tb;
    import ncs_pkg::*;

    localparam int DEPTH_BITS = DEPTH_BITS_DEF;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       i_s_axis_tlast  = 1'b0;    // in_last
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;            // [7:0] out_byte
    logic       o_m_axis_tlast;            // out_last
    logic [1:0] o_m_axis_tuser;            // [1:0] end_status

    int fail_count;
    int pending;

    // Percent of cycles in which the sender or the receiver holds back.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;

    nested_comment_stripper_unit #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    ncs_stream_checker #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_ready   (o_s_axis_tready),
        .i_in_data    (i_s_axis_tdata),
        .i_in_last    (i_s_axis_tlast),
        .i_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .i_out_data   (o_m_axis_tdata),
        .i_out_last   (o_m_axis_tlast),
        .i_out_user   (o_m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The receiver stalls at random with the rate of the current phase.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offers one byte and returns at the edge where the transaction happens.
    // Random gaps with tvalid low come in front of the byte, so a gap can
    // fall on any phase of the unit's work.
    task automatic send_item(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= is_last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Sends a whole text; its final byte carries tlast.
    task automatic send_text(input logic [7:0] txt[$]);
        for (int k = 0; k < txt.size(); k++) send_item(txt[k], k == txt.size() - 1);
    endtask

    task automatic send_str(input string s);
        logic [7:0] txt[$];
        for (int k = 0; k < s.len(); k++) txt = {txt, s[k]};
        send_text(txt);
    endtask

    // Random text: mostly comment openers and closers, line comments,
    // newlines, quotes and backslashes, mixed with code bytes and arbitrary
    // bytes, so that every mode is entered and left with random content.
    task automatic send_random_text(input int len);
        logic [7:0] txt[$];
        int         pick;
        while (txt.size() < len) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                txt = {txt, 8'($urandom_range(126, 32))};
            end else if (pick < 40) begin
                txt = {txt, 8'($urandom_range(255))};
            end else if (pick < 50) begin
                txt = {txt, CH_SLASH, CH_STAR};
            end else if (pick < 60) begin
                txt = {txt, CH_STAR, CH_SLASH};
            end else if (pick < 65) begin
                txt = {txt, CH_SLASH, CH_SLASH};
            end else if (pick < 73) begin
                txt = {txt, CH_NL};
            end else if (pick < 81) begin
                txt = {txt, CH_QUOTE};
            end else if (pick < 86) begin
                txt = {txt, CH_BSLASH};
            end else if (pick < 93) begin
                txt = {txt, CH_SLASH};
            end else begin
                txt = {txt, CH_STAR};
            end
        end
        send_text(txt);
    endtask

    // Opens more block comments than the counter holds, then closes exactly
    // as many as the saturated depth, after which code bytes pass again.
    task automatic send_deep_nesting();
        logic [7:0] txt[$];
        for (int k = 0; k < (1 << DEPTH_BITS) + 2; k++) begin
            txt = {txt, CH_SLASH, CH_STAR};
        end
        for (int k = 0; k < (1 << DEPTH_BITS) - 1; k++) begin
            txt = {txt, CH_STAR, CH_SLASH};
        end
        // The code bytes a and b.
        txt = {txt, 8'h61, 8'h62};
        send_text(txt);
    endtask

    task automatic run_random_phase(input int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target) begin
            // Most texts are short; a few are long.
            if ($urandom_range(9) == 0) send_random_text($urandom_range(120, 41));
            else send_random_text($urandom_range(40, 1));
        end
    endtask

    initial begin
        logic [7:0] txt[$];

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 34;
        recv_idle_pct = 65;

        // Extreme byte values in code.
        txt = '{8'h00, 8'hFF};
        send_text(txt);
        // A held slash that does not start a pair.
        send_str("a/b");
        // Nested block, newline kept inside it, held star without a pair,
        // and a closing pair on the final byte.
        send_str("/*/*\n*x*/*/");
        // A star as the final byte of an open block comment.
        send_str("/**");
        // Line comment ended by its newline, then a slash as the final byte.
        send_str("//x\n/");
        // A line comment still open at the end.
        send_str("//x");
        // An escaped quote, then a backslash as the final byte of a string.
        send_str("\"\\\"\\");

        run_random_phase(280);

        send_idle_pct = 65;
        recv_idle_pct = 34;
        run_random_phase(280);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_deep_nesting();
        run_random_phase(280);

        i_s_axis_tvalid <= 1'b0;
        // The checker publishes the count for the final byte through a register.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #(12 * 400000);
        $display("FAIL");
        $finish;
    end

endmodule

/* nested_comment_stripper_unit.f */
hdl/ncs_pkg.sv
hdl/nested_comment_stripper_unit.sv
sim/ncs_stream_checker.sv
sim/nested_comment_stripper_unit_tb.sv
